/* hw/rtl/scpa_pkg.sv */
package scpa_pkg;

  // Field and register widths of the block's ports.
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Internal arithmetic widths: four 7-bit counts sum into 9 bits, a size times
  // a count needs 23 bits and three such products sum into 25 bits.
  localparam int unsigned SUM_W  = 9;
  localparam int unsigned PROD_W = SIZE_W + CNT_W;
  localparam int unsigned BASE_W = PROD_W + 2;

  // Number of classes that have configuration registers.
  localparam int unsigned NUM_REG_CLASSES = 4;

  // Slot flags are kept in rows of this many bits.
  localparam int unsigned ROW_SHIFT = 5;
  localparam int unsigned ROW_BITS  = 1 << ROW_SHIFT;

  // Register reset values.
  localparam logic [SIZE_W-1:0] SIZE_RST [NUM_REG_CLASSES] =
    '{16'd16, 16'd32, 16'd64, 16'd128};
  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_LOCATE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } scpa_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADCFG = 2'd3
  } scpa_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_A  = 3'd0,
    REG_SIZE_B  = 3'd1,
    REG_SIZE_C  = 3'd2,
    REG_SIZE_D  = 3'd3,
    REG_COUNT_A = 3'd4,
    REG_COUNT_B = 3'd5,
    REG_COUNT_C = 3'd6,
    REG_COUNT_D = 3'd7
  } scpa_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval_en;
    logic rd_first;
    logic rd_next;
    logic clr_flags;
    logic fin_early;
    logic fin_locate;
    logic fin_scan;
  } scpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       cfg_ok;
    scpa_func_e func;
    logic       nofit;
    logic       hit;
    logic       last_row;
  } scpa_stat_t;

endpackage

/* hw/rtl/scpa_datapath.sv */
module scpa_datapath #(
  parameter int unsigned NUM_CLASSES         = 4,
  parameter int unsigned MAX_SLOTS_PER_CLASS = 64,
  parameter int unsigned TOTAL_SLOTS         = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [scpa_pkg::FUNC_W-1:0]     func_i,
  input  logic [scpa_pkg::REQ_W-1:0]      request_size_i,
  input  logic [scpa_pkg::OFF_W-1:0]      pool_offset_i,
  input  scpa_pkg::scpa_cmd_t             cmd_i,
  output scpa_pkg::scpa_stat_t            stat_o,
  output logic [scpa_pkg::CLS_W-1:0]      class_index_o,
  output logic [scpa_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [scpa_pkg::OFF_W-1:0]      class_base_o,
  output logic [scpa_pkg::STAT_W-1:0]     status_o
);
  import scpa_pkg::*;

  localparam int unsigned ACT  = (NUM_CLASSES < NUM_REG_CLASSES) ? NUM_CLASSES : NUM_REG_CLASSES;
  localparam int unsigned ROWS = (TOTAL_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned GW   = RW + ROW_SHIFT;
  localparam int unsigned XW   = ((GW > SUM_W) ? GW : SUM_W) + 1;
  localparam int unsigned TW   = $clog2(TOTAL_SLOTS + 1);
  localparam int unsigned CW   = (TW > SUM_W) ? TW : SUM_W;
  localparam int unsigned MW   = $clog2(MAX_SLOTS_PER_CLASS + 1);
  localparam int unsigned MCW  = (MW > CNT_W) ? MW : CNT_W;

  // Configuration registers.
  logic [SIZE_W-1:0] size_q  [NUM_REG_CLASSES];
  logic [CNT_W-1:0]  count_q [NUM_REG_CLASSES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REG_CLASSES; k++) begin
        size_q[k]  <= SIZE_RST[k];
        count_q[k] <= CNT_RST;
      end
    end else if (cfg_we_i) begin
      case (scpa_reg_e'(cfg_index_i))
        REG_SIZE_A:  size_q[0]  <= cfg_wdata_i;
        REG_SIZE_B:  size_q[1]  <= cfg_wdata_i;
        REG_SIZE_C:  size_q[2]  <= cfg_wdata_i;
        REG_SIZE_D:  size_q[3]  <= cfg_wdata_i;
        REG_COUNT_A: count_q[0] <= cfg_wdata_i[CNT_W-1:0];
        REG_COUNT_B: count_q[1] <= cfg_wdata_i[CNT_W-1:0];
        REG_COUNT_C: count_q[2] <= cfg_wdata_i[CNT_W-1:0];
        REG_COUNT_D: count_q[3] <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Region sizes are registered from the registers, and byte bases from the registered sizes.
  logic [PROD_W-1:0] prod_q [NUM_REG_CLASSES];
  logic [BASE_W-1:0] base_d [NUM_REG_CLASSES];
  logic [BASE_W-1:0] base_q [NUM_REG_CLASSES];

  always_comb begin
    base_d[0] = '0;
    for (int k = 1; k < NUM_REG_CLASSES; k++) begin
      base_d[k] = base_d[k-1] + BASE_W'(prod_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_REG_CLASSES; k++) begin
      prod_q[k] <= PROD_W'(size_q[k]) * PROD_W'(count_q[k]);
      base_q[k] <= base_d[k];
    end
  end

  // Input word capture.
  scpa_func_e       func_q;
  logic [REQ_W-1:0] req_q;
  logic [OFF_W-1:0] off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= scpa_func_e'(func_i);
      req_q  <= request_size_i;
      off_q  <= pool_offset_i;
    end
  end

  // Configuration check, class fit and flag window of the fitting class.
  logic              cfg_ok_d, nofit_d;
  logic [CLS_W-1:0]  fit_d;
  logic [SUM_W-1:0]  fb_lo_d, fb_hi_d, sum_d;
  logic [SIZE_W-1:0] prev_size;

  always_comb begin
    cfg_ok_d  = 1'b1;
    nofit_d   = 1'b1;
    fit_d     = '0;
    fb_lo_d   = '0;
    fb_hi_d   = '0;
    sum_d     = '0;
    prev_size = '0;
    for (int k = 0; k < NUM_REG_CLASSES; k++) begin
      if (k < ACT) begin
        if (size_q[k] <= prev_size) cfg_ok_d = 1'b0;
        prev_size = size_q[k];
        if (count_q[k] == '0 || MCW'(count_q[k]) > MCW'(MAX_SLOTS_PER_CLASS)) begin
          cfg_ok_d = 1'b0;
        end
        if (nofit_d && req_q <= size_q[k]) begin
          nofit_d = 1'b0;
          fit_d   = CLS_W'(k);
          fb_lo_d = sum_d;
          fb_hi_d = sum_d + SUM_W'(count_q[k]);
        end
        sum_d = sum_d + SUM_W'(count_q[k]);
      end
    end
    if (CW'(sum_d) > CW'(TOTAL_SLOTS)) cfg_ok_d = 1'b0;
  end

  logic             cfg_ok_q, nofit_q;
  logic [CLS_W-1:0] cls_q;
  logic [SUM_W-1:0] fb_lo_q, fb_hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_en) begin
      cfg_ok_q <= cfg_ok_d;
      nofit_q  <= nofit_d;
      cls_q    <= fit_d;
      fb_lo_q  <= fb_lo_d;
      fb_hi_q  <= fb_hi_d;
    end
  end

  // Rows of the flag memory that the window spans.
  logic [XW-1:0] lo_x, hi_x, start_row_x, last_row_x;
  logic [RW-1:0] start_row, last_row;

  assign lo_x        = XW'(fb_lo_q);
  assign hi_x        = XW'(fb_hi_q);
  assign start_row_x = lo_x >> ROW_SHIFT;
  assign last_row_x  = (hi_x - XW'(1)) >> ROW_SHIFT;
  assign start_row   = start_row_x[RW-1:0];
  assign last_row    = last_row_x[RW-1:0];

  // Row pointer and read address.
  logic [RW-1:0] row_q, row_d, rd_addr;

  always_comb begin
    row_d   = row_q;
    rd_addr = row_q;
    if (cmd_i.rd_first) begin
      row_d   = start_row;
      rd_addr = start_row;
    end else if (cmd_i.rd_next) begin
      row_d   = RW'(row_q + 1'b1);
      rd_addr = RW'(row_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  // Search the fetched row for the lowest free slot inside the window.
  logic [ROW_BITS-1:0]  rd_data_q, used_eff, avail, pick;
  logic                 rd_vld_q, hit;
  logic [ROW_SHIFT-1:0] pos;
  logic [XW-1:0]        slot_x;

  always_comb begin
    logic [XW-1:0] gi;
    used_eff = rd_vld_q ? rd_data_q : '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      gi       = XW'({row_q, ROW_SHIFT'(b)});
      avail[b] = !used_eff[b] && (gi >= lo_x) && (gi < hi_x);
    end
    pick = avail & (~avail + ROW_BITS'(1));
    pos  = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      if (pick[b]) pos = pos | ROW_SHIFT'(b);
    end
    hit    = |avail;
    slot_x = XW'({row_q, pos}) - lo_x;
  end

  // Slot flag memory; a row whose valid bit is clear reads as all free.
  logic [ROW_BITS-1:0] flag_mem [ROWS];
  logic [ROWS-1:0]     row_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_scan && hit) flag_mem[row_q] <= used_eff | pick;
    rd_data_q <= flag_mem[rd_addr];
    rd_vld_q  <= row_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.clr_flags) begin
      row_vld_q <= '0;
    end else if (cmd_i.fin_scan && hit) begin
      row_vld_q[row_q] <= 1'b1;
    end
  end

  // Locate: last class whose byte base is at or below the offset.
  logic [CLS_W-1:0] loc_cls;

  always_comb begin
    loc_cls = '0;
    for (int k = 0; k < NUM_REG_CLASSES; k++) begin
      if (k < ACT && base_q[k] <= BASE_W'(off_q)) loc_cls = CLS_W'(k);
    end
  end

  // Result registers.
  logic [CLS_W-1:0]  res_cls_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [OFF_W-1:0]  res_base_q;
  scpa_status_e      res_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_early) begin
      res_cls_q  <= '0;
      res_slot_q <= '0;
      res_base_q <= '0;
      if (!cfg_ok_q) begin
        res_status_q <= ST_BADCFG;
      end else if (func_q == FUNC_ALLOC && nofit_q) begin
        res_status_q <= ST_NOFIT;
      end else begin
        res_status_q <= ST_OK;
      end
    end else if (cmd_i.fin_locate) begin
      res_cls_q    <= loc_cls;
      res_slot_q   <= '0;
      res_base_q   <= base_q[loc_cls][OFF_W-1:0];
      res_status_q <= ST_OK;
    end else if (cmd_i.fin_scan) begin
      res_cls_q    <= cls_q;
      res_slot_q   <= hit ? slot_x[SLOT_W-1:0] : '0;
      res_base_q   <= base_q[cls_q][OFF_W-1:0];
      res_status_q <= hit ? ST_OK : ST_FULL;
    end
  end

  assign class_index_o = res_cls_q;
  assign slot_index_o  = res_slot_q;
  assign class_base_o  = res_base_q;
  assign status_o      = STAT_W'(res_status_q);

  // Status toward the controller.
  assign stat_o.cfg_ok   = cfg_ok_q;
  assign stat_o.func     = func_q;
  assign stat_o.nofit    = nofit_q;
  assign stat_o.hit      = hit;
  assign stat_o.last_row = (row_q == last_row);

endmodule

/* hw/rtl/scpa_ctrl.sv */
module scpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  input  scpa_pkg::scpa_stat_t stat_i,
  output scpa_pkg::scpa_cmd_t  cmd_o
);
  import scpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_LOCATE = 5'b01000,
    S_SCAN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Sequencing of one word: evaluate, then dispatch on the function.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval_en = 1'b1;
        state_d       = S_FETCH;
      end
      S_FETCH: begin
        if (!stat_i.cfg_ok) begin
          cmd_o.fin_early = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          case (stat_i.func)
            FUNC_ALLOC: begin
              if (stat_i.nofit) begin
                cmd_o.fin_early = 1'b1;
                done_d          = 1'b1;
                state_d         = S_IDLE;
              end else begin
                cmd_o.rd_first = 1'b1;
                state_d        = S_SCAN;
              end
            end
            FUNC_LOCATE: begin
              state_d = S_LOCATE;
            end
            FUNC_CLEAR: begin
              cmd_o.clr_flags = 1'b1;
              cmd_o.fin_early = 1'b1;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end
            default: begin
              cmd_o.fin_early = 1'b1;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end
          endcase
        end
      end
      S_LOCATE: begin
        cmd_o.fin_locate = 1'b1;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.last_row) begin
          cmd_o.fin_scan = 1'b1;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = done_q;

endmodule

/* hw/rtl/size_class_pool_allocator_top.sv */
// Channel   Direction  Ports                                         Handshake
// command   in         func_i, request_size_i, pool_offset_i         start high, busy low
// result    out        class_index_o, slot_index_o, class_base_o,    result_valid_o, one cycle
//                      status_o
// config    in         cfg_index_i, cfg_wdata_i                      cfg_we_i high
//
// Busy rises the cycle after a word is taken. Invalid configuration, no fit, clear and the
// unused function show their result after the evaluate and fetch states; locate adds the
// locate state. Allocate adds the scan state, which reads one 32-slot row of the flag
// memory at a time, at most the rows the class spans, as the flag memory is single-ported.
// A new word is taken in the cycle the result is shown. Reset clears all slot flags at once
// through per-row valid bits, so no clearing pass follows it. Results cannot be stalled.
module size_class_pool_allocator_top #(
  parameter int unsigned NUM_CLASSES         = 4,
  parameter int unsigned MAX_SLOTS_PER_CLASS = 64,
  parameter int unsigned TOTAL_SLOTS         = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [scpa_pkg::FUNC_W-1:0]     func_i,
  input  logic [scpa_pkg::REQ_W-1:0]      request_size_i,
  input  logic [scpa_pkg::OFF_W-1:0]      pool_offset_i,
  output logic                            result_valid_o,
  output logic [scpa_pkg::CLS_W-1:0]      class_index_o,
  output logic [scpa_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [scpa_pkg::OFF_W-1:0]      class_base_o,
  output logic [scpa_pkg::STAT_W-1:0]     status_o,
  input  logic                            cfg_we_i,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import scpa_pkg::*;

  scpa_cmd_t  cmd;
  scpa_stat_t stat;

  // Sequencer.
  scpa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Registers, base arithmetic, flag memory and result registers.
  scpa_datapath #(
    .NUM_CLASSES         (NUM_CLASSES),
    .MAX_SLOTS_PER_CLASS (MAX_SLOTS_PER_CLASS),
    .TOTAL_SLOTS         (TOTAL_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .request_size_i (request_size_i),
    .pool_offset_i  (pool_offset_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .class_index_o  (class_index_o),
    .slot_index_o   (slot_index_o),
    .class_base_o   (class_base_o),
    .status_o       (status_o)
  );

endmodule

/* hw/rtl/scpa_checker.sv */
module scpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [scpa_pkg::CLS_W-1:0]  class_index_o,
  input logic [scpa_pkg::SLOT_W-1:0] slot_index_o,
  input logic [scpa_pkg::OFF_W-1:0]  class_base_o,
  input logic [scpa_pkg::STAT_W-1:0] status_o
);
  import scpa_pkg::*;

  // A taken word always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after a word was taken");

  // Results come only out of work in progress, one cycle at a time.
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !result_valid_o)
    else $error("result shown without a word in progress");

  // The block is free again in the cycle that shows the result.
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("still busy while the result is shown");

  // An invalid configuration reports nothing but its status.
  a_badcfg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STAT_W'(ST_BADCFG) |->
      class_index_o == '0 && slot_index_o == '0 && class_base_o == '0)
    else $error("invalid configuration result carries nonzero fields");

  // A full class claims no slot.
  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STAT_W'(ST_FULL) |-> slot_index_o == '0)
    else $error("class full result carries a slot index");

endmodule

bind size_class_pool_allocator_top scpa_checker u_scpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .class_index_o  (class_index_o),
  .slot_index_o   (slot_index_o),
  .class_base_o   (class_base_o),
  .status_o       (status_o)
);

/* tb/size_class_pool_allocator_top_tb.sv */
`timescale 1ns / 1ps

module size_class_pool_allocator_top_tb;
  import scpa_pkg::*;

  localparam int unsigned NCLS       = 4;
  localparam int unsigned MAX_SLOTS  = 64;
  localparam int unsigned POOL_SLOTS = 256;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_PHASES  = 12;

  // One command word and the result word it should produce.
  typedef struct {
    scpa_func_e       func;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    bit               drain_first;
  } pool_cmd_t;

  typedef struct {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  base;
    scpa_status_e      status;
  } grant_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i = '0;
  logic [REQ_W-1:0]      request_size_i = '0;
  logic [OFF_W-1:0]      pool_offset_i = '0;
  logic                  result_valid_o;
  logic [CLS_W-1:0]      class_index_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [OFF_W-1:0]      class_base_o;
  logic [STAT_W-1:0]     status_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Mirror of the pool configuration and the slot flags.
  logic [SIZE_W-1:0]   blk_size [NCLS];
  logic [CNT_W-1:0]    blk_count [NCLS];
  bit [POOL_SLOTS-1:0] slot_taken;

  pool_cmd_t cmd_q[$];
  grant_t    grant_q[$];
  pool_cmd_t cur_cmd;
  int        gap_left = 0;
  bit        no_idle = 1'b0;
  int        err_cnt = 0;
  int        checked = 0;
  int        status_seen [4] = '{0, 0, 0, 0};
  int        phases_run = 0;
  int        idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  size_class_pool_allocator_top #(
    .NUM_CLASSES        (NCLS),
    .MAX_SLOTS_PER_CLASS(MAX_SLOTS),
    .TOTAL_SLOTS        (POOL_SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .request_size_i(request_size_i),
    .pool_offset_i (pool_offset_i),
    .result_valid_o(result_valid_o),
    .class_index_o (class_index_o),
    .slot_index_o  (slot_index_o),
    .class_base_o  (class_base_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Byte offset where a class starts; class NCLS gives the end of the pool.
  function automatic int unsigned class_start(int cls);
    int unsigned b;
    int j;
    b = 0;
    for (j = 0; j < cls && j < NCLS; j++) begin
      b += 32'(blk_size[j]) * 32'(blk_count[j]);
    end
    return b;
  endfunction

  function automatic int unsigned flag_start(int cls);
    int unsigned b;
    int j;
    b = 0;
    for (j = 0; j < cls; j++) begin
      b += 32'(blk_count[j]);
    end
    return b;
  endfunction

  function automatic bit pool_cfg_ok();
    int unsigned prev;
    int unsigned total;
    int k;
    prev = 0;
    total = 0;
    for (k = 0; k < NCLS; k++) begin
      if (32'(blk_size[k]) <= prev) return 1'b0;
      prev = 32'(blk_size[k]);
      if (blk_count[k] == 0 || 32'(blk_count[k]) > MAX_SLOTS) return 1'b0;
      total += 32'(blk_count[k]);
    end
    return total <= POOL_SLOTS;
  endfunction

  // Works out the result of one command and updates the slot flags.
  function automatic grant_t grant_for(pool_cmd_t c);
    grant_t g;
    int hit;
    int k;
    int unsigned fb;
    int unsigned s;
    int unsigned b;
    g.cls = '0;
    g.slot = '0;
    g.base = '0;
    g.status = ST_OK;
    if (!pool_cfg_ok()) begin
      g.status = ST_BADCFG;
    end else begin
      case (c.func)
        FUNC_ALLOC: begin
          hit = -1;
          for (k = 0; k < NCLS; k++) begin
            if (hit < 0 && c.req <= blk_size[k]) hit = k;
          end
          if (hit < 0) begin
            g.status = ST_NOFIT;
          end else begin
            // No fall-through: a full class reports full even if larger ones have room.
            fb = flag_start(hit);
            g.cls = CLS_W'(hit);
            g.base = OFF_W'(class_start(hit));
            g.status = ST_FULL;
            for (s = 0; s < 32'(blk_count[hit]); s++) begin
              if (!slot_taken[fb + s]) begin
                slot_taken[fb + s] = 1'b1;
                g.slot = SLOT_W'(s);
                g.status = ST_OK;
                break;
              end
            end
          end
        end
        FUNC_LOCATE: begin
          // Offsets past the end of the pool land in the last class.
          for (k = NCLS - 1; k >= 0; k--) begin
            b = class_start(k);
            if (b <= 32'(c.off)) begin
              g.cls = CLS_W'(k);
              g.base = OFF_W'(b);
              break;
            end
          end
        end
        FUNC_CLEAR: begin
          slot_taken = '0;
        end
        default: begin
        end
      endcase
    end
    return g;
  endfunction

  function automatic pool_cmd_t cmd_of(scpa_func_e f, int unsigned req, int unsigned off);
    pool_cmd_t c;
    c.func = f;
    c.req = REQ_W'(req);
    c.off = OFF_W'(off);
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Register write while the block is idle; the mirror follows the write.
  task automatic write_reg(scpa_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx < REG_COUNT_A) begin
      blk_size[int'(idx)] = data;
    end else begin
      blk_count[int'(idx) - int'(REG_COUNT_A)] = data[CNT_W-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every queued word is taken and every result has come back.
  task automatic settle();
    while (cmd_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Command driver: holds a word until it is taken, then idles for a random gap, or none while no_idle is set.
  always @(posedge clk_i) begin
    logic nxt_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = 1'b0;
      if (start && !busy) begin
        grant_q.push_back(grant_for(cur_cmd));
      end
      if (start && busy) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].drain_first && (grant_q.size() != 0 || result_valid_o))) begin
        cur_cmd = cmd_q.pop_front();
        nxt_start = 1'b1;
        func_i <= cur_cmd.func;
        request_size_i <= cur_cmd.req;
        pool_offset_i <= cur_cmd.off;
        if (no_idle) begin
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:49]:  gap_left = 0;
            [50:84]: gap_left = $urandom_range(1, 3);
            [85:96]: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end
      start <= nxt_start;
    end
  end

  // Result monitor: each strobed word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && result_valid_o) begin
      if (grant_q.size() == 0) begin
        $error("result word with none expected: class %0d slot %0d base %0h status %0d",
               class_index_o, slot_index_o, class_base_o, status_o);
        err_cnt++;
      end else begin
        g = grant_q.pop_front();
        checked++;
        status_seen[int'(g.status)]++;
        if (class_index_o !== g.cls) begin
          $error("class_index: expected %0d, got %0d", g.cls, class_index_o);
          err_cnt++;
        end
        if (slot_index_o !== g.slot) begin
          $error("slot_index: expected %0d, got %0d", g.slot, slot_index_o);
          err_cnt++;
        end
        if (class_base_o !== g.base) begin
          $error("class_base: expected %0h, got %0h", g.base, class_base_o);
          err_cnt++;
        end
        if (status_o !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** size_class_pool_allocator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned dir_req [10] = '{0, 1, 16, 16, 17, 33, 65, 128, 129, 65535};
    int unsigned dir_off [9] = '{0, 47, 48, 559, 560, 1583, 1584, 3632, 24'hFFFFFF};
    logic [SIZE_W-1:0] sz [NCLS];
    logic [CNT_W-1:0]  ct [NCLS];
    pool_cmd_t c;
    int p;
    int k;
    int j;
    int i;
    int kind;
    int n_items;
    int r;
    int unsigned b;
    int unsigned pool_end;

    for (k = 0; k < NCLS; k++) begin
      blk_size[k] = SIZE_RST[k];
      blk_count[k] = CNT_RST;
    end
    slot_taken = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Directed: reset sizes with a three-slot smallest class, so it fills quickly.
    write_reg(REG_COUNT_A, 3);
    foreach (dir_req[i]) cmd_q.push_back(cmd_of(FUNC_ALLOC, dir_req[i], 0));
    foreach (dir_off[i]) cmd_q.push_back(cmd_of(FUNC_LOCATE, 16'hFFFF, dir_off[i]));
    cmd_q.push_back(cmd_of(FUNC_CLEAR, 0, 0));
    cmd_q.push_back(cmd_of(FUNC_NOP, 16'hFFFF, 24'hFFFFFF));
    cmd_q.push_back(cmd_of(FUNC_ALLOC, 16, 0));
    settle();
    // Equal sizes make the setup invalid; a clear then must leave the flags alone.
    write_reg(REG_SIZE_B, 16);
    cmd_q.push_back(cmd_of(FUNC_ALLOC, 1, 0));
    cmd_q.push_back(cmd_of(FUNC_CLEAR, 0, 0));
    cmd_q.push_back(cmd_of(FUNC_LOCATE, 0, 100));
    settle();
    write_reg(REG_SIZE_B, 32);
    cmd_q.push_back(cmd_of(FUNC_ALLOC, 1, 0));
    phases_run = 1;

    // Random phases, each under a fresh pool setup.
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      kind = p % 5;
      no_idle = (p % 4 == 3);
      case (kind)
        1: begin
          // Tiny classes that fill up after a few grants.
          sz[0] = $urandom_range(1, 40);
          for (k = 1; k < NCLS; k++) sz[k] = sz[k-1] + $urandom_range(1, 40);
          for (k = 0; k < NCLS; k++) ct[k] = $urandom_range(1, 4);
        end
        2: begin
          for (k = 0; k < NCLS; k++) begin
            sz[k] = k + 1;
            ct[k] = MAX_SLOTS;
          end
        end
        3: begin
          for (k = 0; k < NCLS; k++) begin
            sz[k] = 16'hFFFF - (NCLS - 1) + k;
            ct[k] = MAX_SLOTS;
          end
        end
        default: begin
          sz[0] = $urandom_range(1, 2000);
          for (k = 1; k < NCLS; k++) sz[k] = sz[k-1] + $urandom_range(1, 8000);
          for (k = 0; k < NCLS; k++) ct[k] = $urandom_range(1, MAX_SLOTS);
        end
      endcase
      // Break one rule of a valid setup.
      if (kind == 4) begin
        j = $urandom_range(1, NCLS - 1);
        case ($urandom_range(0, 4))
          0: sz[0] = '0;
          1: sz[j] = sz[j-1];
          2: sz[j] = sz[j-1] - 1;
          3: ct[j] = '0;
          default: ct[j] = $urandom_range(MAX_SLOTS + 1, 127);
        endcase
      end
      for (k = 0; k < NCLS; k++) write_reg(scpa_reg_e'(int'(REG_SIZE_A) + k), sz[k]);
      for (k = 0; k < NCLS; k++) begin
        write_reg(scpa_reg_e'(int'(REG_COUNT_A) + k), CFG_DATA_W'(ct[k]));
      end
      phases_run++;

      n_items = (kind == 4) ? 30 : 120;
      pool_end = class_start(NCLS);
      for (i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, NCLS - 1);
        c = cmd_of(FUNC_NOP, $urandom, $urandom);
        if (r < 70) begin
          // Request sizes cluster on the class boundaries.
          c.func = FUNC_ALLOC;
          case ($urandom_range(0, 5))
            0: c.req = blk_size[k] - 16'd1;
            1: c.req = blk_size[k];
            2: c.req = blk_size[k] + 16'd1;
            3: c.req = $urandom_range(0, blk_size[k]);
            4: c.req = '0;
            default: c.req = $urandom;
          endcase
        end else if (r < 94) begin
          c.func = FUNC_LOCATE;
          b = class_start(k);
          case ($urandom_range(0, 5))
            0: c.off = OFF_W'(b - 1);
            1: c.off = OFF_W'(b);
            2: c.off = OFF_W'(b + 1);
            3: c.off = OFF_W'($urandom_range(0, pool_end));
            4: c.off = OFF_W'(pool_end + $urandom_range(0, 1000));
            default: c.off = $urandom;
          endcase
        end else if (r < 97) begin
          c.func = FUNC_CLEAR;
        end
        c.drain_first = ($urandom_range(0, 49) == 0);
        cmd_q.push_back(c);
      end
    end

    settle();
    $display("Checked %0d result words over %0d pool setups.", checked, phases_run);
    $display("Grants %0d, no fit %0d, class full %0d, invalid setup %0d.",
             status_seen[int'(ST_OK)], status_seen[int'(ST_NOFIT)],
             status_seen[int'(ST_FULL)], status_seen[int'(ST_BADCFG)]);
    if (err_cnt == 0) begin
      $display("** size_class_pool_allocator_top: PASSED **");
    end else begin
      $display("** size_class_pool_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/scpa_pkg.sv
hw/rtl/scpa_datapath.sv
hw/rtl/scpa_ctrl.sv
hw/rtl/size_class_pool_allocator_top.sv
hw/rtl/scpa_checker.sv
tb/size_class_pool_allocator_top_tb.sv
